/* rtl/core/checked_signed_alu_top_assert.svh */
// Assertion macros for the checked signed ALU.
`ifndef CHECKED_SIGNED_ALU_TOP_ASSERT_SVH
`define CHECKED_SIGNED_ALU_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSALU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("checked_signed_alu assertion failed");

// Next-cycle implication, disabled during reset.
`define CSALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("checked_signed_alu assertion failed");

`endif

/* rtl/core/csalu_pkg.sv */
// Package: word types, codes and pipeline types for the checked signed ALU.
`timescale 1ns / 1ps
package csalu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned DivSteps = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_REM = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_word_t;

  // Travels alongside the divider array.
  typedef struct packed {
    logic        use_div;
    logic        is_rem;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] value;
    logic [1:0]  status;
  } side_t;

endpackage

/* rtl/core/csalu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
module csalu_div
  import csalu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [DataW-1:0]    dividend,
  input  logic [DataW-1:0]    divisor,
  input  side_t               in_side,
  output logic                out_valid,
  output logic [DataW-1:0]    quotient,
  output logic [DataW-1:0]    remainder,
  output side_t               out_side
);

  logic [2*DataW-1:0] pr   [0:DivSteps];
  logic [DataW-1:0]   dv   [0:DivSteps];
  side_t              sd   [0:DivSteps];
  logic [DivSteps:0]  vl;

  assign pr[0] = {{DataW{1'b0}}, dividend};
  assign dv[0] = divisor;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DataW-1:0]   hi;
    logic [DataW:0]     diff;
    logic [2*DataW-1:0] pr_next;

    always_comb begin
      hi   = pr[i][2*DataW-2:DataW-1];
      diff = {1'b0, hi} - {1'b0, dv[i]};
      if (!diff[DataW]) begin
        pr_next = {diff[DataW-1:0], pr[i][DataW-2:0], 1'b1};
      end else begin
        pr_next = {hi, pr[i][DataW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
      pr[i+1] <= pr_next;
      dv[i+1] <= dv[i];
      sd[i+1] <= sd[i];
    end
  end

  assign out_valid = vl[DivSteps];
  assign quotient  = pr[DivSteps][DataW-1:0];
  assign remainder = pr[DivSteps][2*DataW-1:DataW];
  assign out_side  = sd[DivSteps];

endmodule

/* rtl/core/checked_signed_alu_top.sv */
// Checked signed 64-bit ALU. Throughput one word per cycle; busy is always
// low. Synchronous reset clears all valid bits, not the data registers.
// Five front stages (input register, add/sub, 32x32 partial products,
// middle sum, product sum), then a 64-stage divider pipeline that every
// word passes, then the output register.
`timescale 1ns / 1ps
module checked_signed_alu_top
  import csalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      done,
  output out_word_t result
);

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;

  assign busy = 1'b0;

  // s1: input register
  logic     v1;
  in_word_t w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    w1 <= in_word;
  end

  // s2: magnitudes, add/sub, division special cases
  logic        v2;
  logic [2:0]  cmd2;
  logic [63:0] ma2, mb2;
  logic        na2, nb2;
  side_t       sd2;
  side_t       sd2_next;
  logic [63:0] a1, b1, sum1, dif1;

  always_comb begin
    a1   = w1.operand_a;
    b1   = w1.operand_b;
    sum1 = a1 + b1;
    dif1 = a1 - b1;
    sd2_next.use_div = 1'b0;
    sd2_next.is_rem  = (w1.command == CMD_REM);
    sd2_next.neg_q   = a1[63] ^ b1[63];
    sd2_next.neg_r   = a1[63];
    sd2_next.value   = '0;
    sd2_next.status  = ST_OK;
    case (w1.command)
      CMD_ADD: begin
        if (((a1 ^ sum1) & (b1 ^ sum1)) >= MinVal) sd2_next.status = ST_OVF;
        else sd2_next.value = sum1;
      end
      CMD_SUB: begin
        if (((a1 ^ b1) & (a1 ^ dif1)) >= MinVal) sd2_next.status = ST_OVF;
        else sd2_next.value = dif1;
      end
      CMD_DIV, CMD_REM: begin
        if (b1 == '0) sd2_next.status = ST_DIV0;
        else if (w1.command == CMD_DIV && a1 == MinVal && b1 == '1)
          sd2_next.status = ST_OVF;
        else sd2_next.use_div = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cmd2 <= w1.command;
    ma2  <= a1[63] ? (64'd0 - a1) : a1;
    mb2  <= b1[63] ? (64'd0 - b1) : b1;
    na2  <= a1[63];
    nb2  <= b1[63];
    sd2  <= sd2_next;
  end

  // s3: partial products
  logic        v3;
  logic [2:0]  cmd3;
  logic        neg3;
  logic [63:0] ma3, mb3;
  logic [63:0] p00, p01, p10, p11;
  side_t       sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    cmd3 <= cmd2;
    neg3 <= na2 ^ nb2;
    ma3  <= ma2;
    mb3  <= mb2;
    sd3  <= sd2;
    p00  <= ma2[31:0]  * mb2[31:0];
    p01  <= ma2[31:0]  * mb2[63:32];
    p10  <= ma2[63:32] * mb2[31:0];
    p11  <= ma2[63:32] * mb2[63:32];
  end

  // s4: middle sum
  logic         v4;
  logic [2:0]   cmd4;
  logic         neg4;
  logic [63:0]  ma4, mb4;
  logic [127:0] pp4;
  logic [64:0]  mid4;
  side_t        sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    cmd4 <= cmd3;
    neg4 <= neg3;
    ma4  <= ma3;
    mb4  <= mb3;
    sd4  <= sd3;
    pp4  <= {p11, p00};
    mid4 <= {1'b0, p01} + {1'b0, p10};
  end

  // s5: full product and multiply check
  logic         v5;
  logic [63:0]  ma5, mb5;
  side_t        sd5;
  side_t        sd5_next;
  logic [127:0] prod4;

  always_comb begin
    prod4    = pp4 + {31'd0, mid4, 32'd0};
    sd5_next = sd4;
    if (cmd4 == CMD_MUL) begin
      if (prod4[127:64] != '0 ||
          (neg4 ? (prod4[63:0] > MinVal) : (prod4[63:0] >= MinVal))) begin
        sd5_next.status = ST_OVF;
      end else begin
        sd5_next.value = neg4 ? (64'd0 - prod4[63:0]) : prod4[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    ma5 <= ma4;
    mb5 <= mb4;
    sd5 <= sd5_next;
  end

  // divider array
  logic        vd;
  logic [63:0] quo, rem;
  side_t       sdd;

  csalu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .dividend  (ma5),
    .divisor   (mb5),
    .in_side   (sd5),
    .out_valid (vd),
    .quotient  (quo),
    .remainder (rem),
    .out_side  (sdd)
  );

  // output register
  out_word_t result_next;

  always_comb begin
    result_next.value  = sdd.value;
    result_next.status = sdd.status;
    if (sdd.use_div) begin
      if (sdd.is_rem) result_next.value = sdd.neg_r ? (64'd0 - rem) : rem;
      else result_next.value = sdd.neg_q ? (64'd0 - quo) : quo;
      result_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    result <= result_next;
  end

`include "checked_signed_alu_top_assert.svh"

  `CSALU_ASSERT_IMPLY(a_err_zero, done && result.status != ST_OK, result.value == '0)
  `CSALU_ASSERT_IMPLY(a_status_legal, done, result.status != 2'd3)
  `CSALU_ASSERT_NEXT(a_div_done, vd, done)

endmodule
